@@ hdl/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_LEFTOVER  = 3'd1;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
  localparam logic [2:0] ERR_DIVZERO   = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  // Stack cell moves
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_UP,
    CELL_DOWN
  } cell_op_t;

  // Request to the multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_req_t;

endpackage

@@ hdl/rpn_cell.sv @@
// ----------------------------------------------------------------------------
// rpn_cell
// One stack entry. Takes the neighbor above on a push, the neighbor below
// on a two-pop-one-push, or holds.
// ----------------------------------------------------------------------------
module rpn_cell #(
  parameter int W = 32
) (
  input  logic              clk,
  input  rpn_pkg::cell_op_t op,
  input  logic [W-1:0]      up_val,
  input  logic [W-1:0]      down_val,
  output logic [W-1:0]      q
);
  import rpn_pkg::*;

  logic [W-1:0] val_r;
  logic [W-1:0] val_nxt;

  always_comb begin
    unique case (op)
      CELL_UP:   val_nxt = up_val;
      CELL_DOWN: val_nxt = down_val;
      default:   val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

@@ hdl/rpn_mdu.sv @@
// ----------------------------------------------------------------------------
// rpn_mdu
// Iterative multiply (shift-add) and signed divide (restoring, truncating
// toward zero), one bit per cycle: a load, W shift steps, then a done pulse.
// ----------------------------------------------------------------------------
module rpn_mdu #(
  parameter int W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rpn_pkg::mdu_req_t req,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic              done,
  output logic [W-1:0]      result
);
  import rpn_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy_r, done_r, div_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  x_r, y_r;
  logic [W:0]    acc_r;
  logic [W:0]    rem_sh;
  logic [W-1:0]  mag_a, mag_b;

  assign mag_a  = a[W-1] ? (~a + 1'b1) : a;
  assign mag_b  = b[W-1] ? (~b + 1'b1) : b;
  assign rem_sh = {acc_r[W-1:0], x_r[W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_r <= req.is_div;
      neg_r <= a[W-1] ^ b[W-1];
      acc_r <= '0;
      x_r   <= req.is_div ? mag_a : a;
      y_r   <= req.is_div ? mag_b : b;
    end else if (busy_r) begin
      if (div_r) begin
        // restore unless the shifted remainder covers the divisor
        if (rem_sh >= {1'b0, y_r}) begin
          acc_r <= rem_sh - {1'b0, y_r};
          x_r   <= {x_r[W-2:0], 1'b1};
        end else begin
          acc_r <= rem_sh;
          x_r   <= {x_r[W-2:0], 1'b0};
        end
      end else begin
        if (y_r[0]) begin
          acc_r <= {1'b0, acc_r[W-1:0] + x_r};
        end
        x_r <= {x_r[W-2:0], 1'b0};
        y_r <= {1'b0, y_r[W-1:1]};
      end
    end
  end

  assign done   = done_r;
  assign result = div_r ? (neg_r ? (~x_r + 1'b1) : x_r) : acc_r[W-1:0];

endmodule

@@ hdl/postfix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Postfix (RPN) evaluator over a byte stream, built on a chain of stack cells.
// ----------------------------------------------------------------------------
// Usage:
//   Send expression bytes on in_char_code with in_valid/in_ready. Space
//   closes a token; a zero byte closes the last token and ends the
//   expression. One beat per expression leaves on out_result_value and
//   out_error_code with out_valid/out_ready.
// Timing:
//   Ordinary bytes, spaces closing numbers and the + and - operators are
//   taken without a stall. A space closing * or / (two values present and,
//   for /, a nonzero divisor) holds in_ready low while the shared shift-add /
//   restoring divide unit runs.
//   A zero byte also passes through a finish state that loads the result
//   register (after the operator when it closes * or /).
// Stall:
//   A finished result waits in the output register; bytes of the next
//   expression are still taken meanwhile. After its terminator, in_ready
//   stays low until the pending beat has been taken.
// Reset:
//   Stack count, token state and error are cleared; stack cells are not.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64,
  parameter int TOKEN_MAX   = 15,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_value,
  output logic [2:0]  out_error_code
);
  import rpn_pkg::*;

  localparam int W    = VALUE_WIDTH;
  localparam int CNTW = $clog2(STACK_DEPTH + 1);
  localparam int LENW = $clog2(TOKEN_MAX + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_BUSY   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [LENW-1:0] len_r, len_nxt;
  logic [7:0]      first_r, first_nxt;
  logic [W-1:0]    acc_r, acc_nxt;
  logic            neg_r, neg_nxt;
  logic            stopped_r, stopped_nxt;
  logic            lead_r, lead_nxt;
  logic [2:0]      sticky_r, sticky_nxt;
  logic            end_pend_r, end_pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_value_r;
  logic [2:0]      out_err_r;

  logic            accept, is_op, do_push, do_merge, fin_load;
  logic [W-1:0]    load_val, num_val, top_val, sec_val, mdu_result;
  logic [2:0]      fin_err;
  logic            mdu_done;
  mdu_req_t        mdu_req;
  logic [W-1:0]    cell_q [STACK_DEPTH];
  cell_op_t        cell_op [STACK_DEPTH];

  assign accept  = in_valid && in_ready;
  assign top_val = cell_q[0];
  assign sec_val = cell_q[1];
  assign num_val = neg_r ? (~acc_r + 1'b1) : acc_r;
  assign is_op   = (len_r == LENW'(1)) &&
                   (first_r == CH_PLUS || first_r == CH_MINUS ||
                    first_r == CH_STAR || first_r == CH_SLASH);

  always_comb begin
    priority if (sticky_r != ERR_NONE)   fin_err = sticky_r;
    else if (count_r == '0)              fin_err = ERR_UNDERFLOW;
    else if (count_r > CNTW'(1))         fin_err = ERR_LEFTOVER;
    else                                 fin_err = ERR_NONE;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    first_nxt     = first_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    stopped_nxt   = stopped_r;
    lead_nxt      = lead_r;
    sticky_nxt    = sticky_r;
    end_pend_nxt  = end_pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    do_push       = 1'b0;
    do_merge      = 1'b0;
    load_val      = num_val;
    mdu_req       = '0;
    fin_load      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_char_code == CH_SPACE || in_char_code == CH_NUL) begin
            if (in_char_code == CH_NUL) begin
              state_nxt = S_FINISH;
            end
            if (len_r != '0) begin
              len_nxt     = '0;
              first_nxt   = '0;
              acc_nxt     = '0;
              neg_nxt     = 1'b0;
              stopped_nxt = 1'b0;
              lead_nxt    = 1'b0;
              if (is_op) begin
                if (count_r < CNTW'(2)) begin
                  if (sticky_r == ERR_NONE) sticky_nxt = ERR_UNDERFLOW;
                end else if (first_r == CH_PLUS) begin
                  do_merge = 1'b1;
                  load_val = sec_val + top_val;
                end else if (first_r == CH_MINUS) begin
                  do_merge = 1'b1;
                  load_val = sec_val - top_val;
                end else if (first_r == CH_SLASH && top_val == '0) begin
                  do_merge = 1'b1;
                  load_val = '0;
                  if (sticky_r == ERR_NONE) sticky_nxt = ERR_DIVZERO;
                end else begin
                  // hand the operands to the shared unit and wait
                  mdu_req.start  = 1'b1;
                  mdu_req.is_div = (first_r == CH_SLASH);
                  end_pend_nxt   = (in_char_code == CH_NUL);
                  state_nxt      = S_BUSY;
                end
              end else if (count_r < CNTW'(STACK_DEPTH)) begin
                do_push = 1'b1;
              end else if (sticky_r == ERR_NONE) begin
                sticky_nxt = ERR_OVERFLOW;
              end
            end
          end else if (len_r >= LENW'(TOKEN_MAX)) begin
            // drop bytes past the token limit
            if (sticky_r == ERR_NONE) sticky_nxt = ERR_OVERFLOW;
          end else begin
            if (len_r == '0) first_nxt = in_char_code;
            len_nxt = len_r + 1'b1;
            if (!stopped_r) begin
              if (!lead_r && in_char_code >= CH_TAB && in_char_code <= CH_CR) begin
                lead_nxt = 1'b0;
              end else if (!lead_r &&
                           (in_char_code == CH_PLUS || in_char_code == CH_MINUS)) begin
                lead_nxt = 1'b1;
                neg_nxt  = (in_char_code == CH_MINUS);
              end else begin
                lead_nxt = 1'b1;
                if (in_char_code >= CH_ZERO && in_char_code <= CH_NINE) begin
                  acc_nxt = (acc_r << 3) + (acc_r << 1) + W'(in_char_code[3:0]);
                end else begin
                  stopped_nxt = 1'b1;
                end
              end
            end
          end
        end
      end
      S_BUSY: begin
        if (mdu_done) begin
          do_merge  = 1'b1;
          load_val  = mdu_result;
          state_nxt = end_pend_r ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          fin_load      = 1'b1;
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          sticky_nxt    = ERR_NONE;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (do_push) count_nxt = count_r + 1'b1;
    if (do_merge) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      len_r       <= '0;
      first_r     <= '0;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      stopped_r   <= 1'b0;
      lead_r      <= 1'b0;
      sticky_r    <= ERR_NONE;
      end_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      len_r       <= len_nxt;
      first_r     <= first_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      stopped_r   <= stopped_nxt;
      lead_r      <= lead_nxt;
      sticky_r    <= sticky_nxt;
      end_pend_r  <= end_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_value_r <= (count_r == '0) ? 32'd0 : 32'(signed'(top_val));
      out_err_r   <= fin_err;
    end
  end

  // Stack: cell 0 is the top; a push shifts down, a merge loads the top and
  // pulls the cells under the two operands up by one
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [W-1:0] up_v, down_v;
    if (i == 0) begin : g_top
      assign up_v = load_val;
    end else begin : g_mid
      assign up_v = cell_q[i-1];
    end
    if (i + 1 < STACK_DEPTH) begin : g_down
      assign down_v = cell_q[i+1];
    end else begin : g_bottom
      assign down_v = '0;
    end
    always_comb begin
      priority if (do_push)      cell_op[i] = CELL_UP;
      else if (do_merge)         cell_op[i] = (i == 0) ? CELL_UP : CELL_DOWN;
      else                       cell_op[i] = CELL_HOLD;
    end
    rpn_cell #(.W(W)) u_cell (
      .clk      (clk),
      .op       (cell_op[i]),
      .up_val   (up_v),
      .down_val (down_v),
      .q        (cell_q[i])
    );
  end

  rpn_mdu #(.W(W)) u_mdu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mdu_req),
    .a      (sec_val),
    .b      (top_val),
    .done   (mdu_done),
    .result (mdu_result)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_error_code   = out_err_r;

endmodule

@@ hdl/rpn_checker.sv @@
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks for the postfix expression evaluator.
// ----------------------------------------------------------------------------
module rpn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_char_code,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_value,
  input logic [2:0]  out_error_code
);
  import rpn_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value) &&
                                $stable(out_error_code))
    else $error("result beat changed while stalled");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code <= ERR_OVERFLOW)
    else $error("error code out of range");

  // a new result beat only follows a terminator
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_char_code != CH_NUL |=> !$rose(out_valid))
    else $error("result beat without terminator");

  // no byte is taken right after a terminator; the result is posted first
  a_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_char_code == CH_NUL |=> !in_ready)
    else $error("input taken right after terminator");

endmodule

bind postfix_expression_evaluator rpn_checker u_rpn_checker (.*);
